// ===== sv/ile_pkg.sv =====
// Package for the indexed list engine: request, status and state codes.
`timescale 1ns / 1ps

package ile_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_ERASE  = 3'd3,
    REQ_GET    = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GET,
    S_SHIFT,
    S_DONE
  } state_e;

  localparam int unsigned POS_W  = 9;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned DATA_W = 48;

endpackage

// ===== sv/indexed_list_engine.sv =====
// Top level of the indexed list engine: ordered word list held in one memory.
//
//  channel   dir  tdata fields (low bit up)               tuser
//  s_axis    in   position[8:0], value[40:9]              req_type[2:0]
//  m_axis    out  read_value[31:0], length[40:32],        -
//                 status[42:41]
//
// Push, pop, clear, unused kinds and refused requests go from S_EXEC straight to
// S_DONE; get reads the store through S_GET. Insert and erase move one word per
// cycle through the single memory port pair in S_SHIFT, then finish in S_DONE.
// Reset clears the word count and the control state; the store is not cleared.
// A result waits in the output register; the engine accepts the next item while
// it waits, and a finished request holds until the output register is free.
`timescale 1ns / 1ps

module indexed_list_engine import ile_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // position[8:0], value[40:9]
  input  logic [2:0]        s_axis_tuser,   // req_type[2:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata    // read_value[31:0], length[40:32], status[42:41]
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  // word store
  logic [WORD_W-1:0] mem [CAPACITY];
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [WORD_W-1:0] mem_wd;
  logic [AW-1:0]     mem_ra;
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     dst_q, dst_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;

  req_e              req_q, req_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [WORD_W-1:0] val_q, val_d;
  logic [WORD_W-1:0] res_rd_q, res_rd_d;
  status_e           res_st_q, res_st_d;

  logic [XW-1:0]     cnt_x, pos_x, len_x;
  logic              full;
  logic              out_free;
  logic              more;

  assign cnt_x    = XW'(count_q);
  assign pos_x    = XW'(pos_q);
  assign full     = (count_q >= CW'(CAPACITY));
  assign out_free = !out_valid_q || m_axis_tready;
  assign len_x    = XW'(count_q);

  // insert walks down from the top, erase walks up from the position
  always_comb begin
    if (req_q == REQ_INSERT) begin
      more = (XW'(ptr_q) > pos_x);
    end else begin
      more = ((XW'(ptr_q) + XW'(1)) < cnt_x);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    dst_q      <= dst_d;
    out_data_q <= out_data_d;
    req_q      <= req_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    res_rd_q   <= res_rd_d;
    res_st_q   <= res_st_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    dst_d       = dst_q;
    pend_d      = pend_q;
    out_data_d  = out_data_q;
    req_d       = req_q;
    pos_d       = pos_q;
    val_d       = val_q;
    res_rd_d    = res_rd_q;
    res_st_d    = res_st_q;
    mem_we      = 1'b0;
    mem_wa      = count_q[AW-1:0];
    mem_wd      = val_q;
    mem_ra      = pos_x[AW-1:0];
    s_axis_tready = 1'b0;

    out_valid_d = out_valid_q && !m_axis_tready;

    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          req_d   = req_e'(s_axis_tuser);
          pos_d   = s_axis_tdata[POS_W-1:0];
          val_d   = s_axis_tdata[POS_W+WORD_W-1:POS_W];
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_rd_d = '0;
        res_st_d = ST_OK;
        state_d  = S_DONE;
        case (req_q)
          REQ_PUSH: begin
            if (full) begin
              res_st_d = ST_FULL;
            end else begin
              mem_we  = 1'b1;
              mem_wa  = count_q[AW-1:0];
              mem_wd  = val_q;
              count_d = count_q + CW'(1);
            end
          end
          REQ_POP: begin
            if (count_q != '0) begin
              count_d = count_q - CW'(1);
            end
          end
          REQ_INSERT: begin
            if (pos_x > cnt_x) begin
              res_st_d = ST_RANGE;
            end else if (full) begin
              res_st_d = ST_FULL;
            end else begin
              ptr_d   = count_q;
              pend_d  = 1'b0;
              state_d = S_SHIFT;
            end
          end
          REQ_ERASE: begin
            if (pos_x >= cnt_x) begin
              res_st_d = ST_RANGE;
            end else begin
              ptr_d   = pos_x[CW-1:0];
              pend_d  = 1'b0;
              state_d = S_SHIFT;
            end
          end
          REQ_GET: begin
            if (pos_x >= cnt_x) begin
              res_st_d = ST_RANGE;
            end else begin
              mem_ra  = pos_x[AW-1:0];
              state_d = S_GET;
            end
          end
          REQ_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
      end

      S_GET: begin
        res_rd_d = rdata_q;
        state_d  = S_DONE;
      end

      S_SHIFT: begin
        // write back the word read last cycle, one slot away from its source
        if (pend_q) begin
          mem_we = 1'b1;
          mem_wa = dst_q;
          mem_wd = rdata_q;
        end
        if (more) begin
          if (req_q == REQ_INSERT) begin
            mem_ra = AW'(ptr_q - CW'(1));
            ptr_d  = ptr_q - CW'(1);
          end else begin
            mem_ra = AW'(ptr_q + CW'(1));
            ptr_d  = ptr_q + CW'(1);
          end
          dst_d  = ptr_q[AW-1:0];
          pend_d = 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          if (req_q == REQ_INSERT) begin
            mem_we  = 1'b1;
            mem_wa  = pos_x[AW-1:0];
            mem_wd  = val_q;
            count_d = count_q + CW'(1);
          end else begin
            count_d = count_q - CW'(1);
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {5'd0, res_st_q, len_x[LEN_W-1:0], res_rd_q};
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== test/list_model_pkg.sv =====
// Scoreboard for the indexed list engine: list predictor and result checker.
`timescale 1ns / 1ps

package list_model_pkg;
  import ile_pkg::*;

  localparam int unsigned LIST_CAPACITY = 256;

  typedef struct {
    logic [WORD_W-1:0] read_value;
    logic [LEN_W-1:0]  length;
    status_e           status;
  } list_result_t;

  class list_scoreboard;
    logic [WORD_W-1:0] words [LIST_CAPACITY];
    int unsigned       word_count;
    list_result_t      pending_results [$];
    int unsigned       errors;

    function new();
      word_count = 0;
      errors     = 0;
    endfunction

    function int unsigned length();
      return word_count;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    // Apply one accepted request to the shadow list and queue its result.
    function void note_request(logic [2:0] kind, logic [POS_W-1:0] pos,
                               logic [WORD_W-1:0] value);
      list_result_t res;
      int unsigned  p;
      p              = pos;
      res.read_value = '0;
      res.status     = ST_OK;
      case (kind)
        REQ_PUSH: begin
          if (word_count >= LIST_CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            words[word_count] = value;
            word_count++;
          end
        end
        REQ_POP: begin
          if (word_count > 0) word_count--;
        end
        REQ_INSERT: begin
          // range check wins over the full check
          if (p > word_count) begin
            res.status = ST_RANGE;
          end else if (word_count >= LIST_CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            for (int unsigned i = word_count; i > p; i--) words[i] = words[i-1];
            words[p] = value;
            word_count++;
          end
        end
        REQ_ERASE: begin
          if (p >= word_count) begin
            res.status = ST_RANGE;
          end else begin
            for (int unsigned i = p; i + 1 < word_count; i++) words[i] = words[i+1];
            word_count--;
          end
        end
        REQ_GET: begin
          if (p >= word_count) res.status = ST_RANGE;
          else res.read_value = words[p];
        end
        REQ_CLEAR: word_count = 0;
        default: ;
      endcase
      res.length = word_count[LEN_W-1:0];
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [DATA_W-1:0] tdata);
      list_result_t      want;
      logic [WORD_W-1:0] got_value;
      logic [LEN_W-1:0]  got_length;
      logic [1:0]        got_status;
      got_value  = tdata[WORD_W-1:0];
      got_length = tdata[WORD_W+LEN_W-1:WORD_W];
      got_status = tdata[WORD_W+LEN_W+1:WORD_W+LEN_W];
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request waiting, tdata %h", $time, tdata);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got_value !== want.read_value) begin
        $display("%0t: read_value expected %0d actual %0d", $time,
                 $signed(want.read_value), $signed(got_value));
        errors++;
      end
      if (got_length !== want.length) begin
        $display("%0t: length expected %0d actual %0d", $time, want.length, got_length);
        errors++;
      end
      if (got_status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== test/tb.sv =====
// Testbench top for the indexed list engine: directed and random requests.
`timescale 1ns / 1ps

module tb;
  import ile_pkg::*;
  import list_model_pkg::*;

  localparam logic [2:0]  REQ_SPARE_A     = 3'd6;
  localparam logic [2:0]  REQ_SPARE_B     = 3'd7;
  localparam int unsigned ITEMS_PER_PHASE = 356;
  localparam int unsigned FULL_EXTRA      = 8;
  localparam int unsigned QUIET_LIMIT     = 5000;
  localparam int unsigned DRAIN_CYCLES    = LIST_CAPACITY + 16;

  logic              clk_i    = 1'b0;
  logic              rst_ni   = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata  = '0;   // position[8:0], value[40:9]
  logic [2:0]        s_tuser  = '0;   // req_type[2:0]
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;         // read_value[31:0], length[40:32], status[42:41]

  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct     = 0;
  int unsigned    quiet_cycles  = 0;
  list_scoreboard board;

  indexed_list_engine #(.CAPACITY(LIST_CAPACITY)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // End the run when no item moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(input logic [2:0] kind, input logic [POS_W-1:0] pos,
                              input logic [WORD_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(DATA_W-WORD_W-POS_W){1'b0}}, value, pos};
    do @(posedge clk_i); while (!s_tready);
    board.note_request(kind, pos, value);
  endtask

  task automatic random_request(input bit filling);
    int unsigned       n;
    int unsigned       r;
    int unsigned       sel;
    logic [2:0]        kind;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] value;
    n     = board.length();
    r     = $urandom_range(99);
    sel   = $urandom_range(19);
    value = $urandom();
    pos   = POS_W'($urandom_range(511));
    if (filling) begin
      if (r < 55) kind = REQ_PUSH;
      else if (r < 90) kind = REQ_INSERT;
      else kind = REQ_GET;
    end else begin
      if (r < 20) kind = REQ_PUSH;
      else if (r < 32) kind = REQ_POP;
      else if (r < 52) kind = REQ_INSERT;
      else if (r < 72) kind = REQ_ERASE;
      else if (r < 88) kind = REQ_GET;
      else if (r < 91) kind = REQ_CLEAR;
      else if (r < 94) kind = r[0] ? REQ_SPARE_A : REQ_SPARE_B;
      else kind = 3'($urandom_range(7));
    end
    // mostly legal positions, some just past the end, a few anywhere
    if (r < 94 && sel != 0) begin
      if (kind == REQ_INSERT) begin
        pos = (sel == 1) ? POS_W'(n + 1) : POS_W'($urandom_range(n));
      end else if (kind == REQ_ERASE || kind == REQ_GET) begin
        if (sel == 1 || n == 0) pos = POS_W'(n);
        else pos = POS_W'($urandom_range(n - 1));
      end
    end
    send_request(kind, pos, value);
  endtask

  initial begin
    bit          filling;
    int unsigned extra;
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list corners
    send_request(REQ_POP,    9'd0,   32'h0);
    send_request(REQ_ERASE,  9'd0,   32'h0);
    send_request(REQ_GET,    9'd0,   32'h0);
    send_request(REQ_INSERT, 9'd1,   32'h1);
    // insert at the count appends
    send_request(REQ_INSERT, 9'd0,   32'h7FFF_FFFF);
    send_request(REQ_PUSH,   9'd0,   32'h8000_0000);
    send_request(REQ_PUSH,   9'd0,   32'h0);
    send_request(REQ_PUSH,   9'd0,   32'hFFFF_FFFF);
    send_request(REQ_INSERT, 9'd1,   32'h1234_5678);
    send_request(REQ_INSERT, 9'd0,   32'hA5A5_A5A5);
    send_request(REQ_GET,    9'd0,   32'h0);
    send_request(REQ_GET,    9'd5,   32'h0);
    send_request(REQ_GET,    9'd6,   32'h0);
    send_request(REQ_GET,    9'd511, 32'hFFFF_FFFF);
    send_request(REQ_ERASE,  9'd2,   32'h0);
    send_request(REQ_ERASE,  9'd5,   32'h0);
    send_request(REQ_ERASE,  9'd4,   32'h0);
    send_request(REQ_ERASE,  9'd0,   32'h0);
    send_request(REQ_SPARE_A, 9'd0,  32'h5555_5555);
    send_request(REQ_SPARE_B, 9'd511, 32'hFFFF_FFFF);
    send_request(REQ_POP,    9'd0,   32'h0);
    send_request(REQ_GET,    9'd256, 32'h0);
    send_request(REQ_INSERT, 9'd256, 32'h0);
    send_request(REQ_CLEAR,  9'd0,   32'h0);
    send_request(REQ_GET,    9'd0,   32'h0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      // odd phases grow the list to capacity, then hammer the full store
      filling = phase[0];
      extra   = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_request(filling);
        if (filling && board.length() == LIST_CAPACITY) begin
          extra++;
          if (extra > FULL_EXTRA) filling = 1'b0;
        end
      end
    end
    s_tvalid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== indexed_list_engine.f =====
sv/ile_pkg.sv
sv/indexed_list_engine.sv
test/list_model_pkg.sv
test/tb.sv
